FILE: hdl/svcv_pkg.sv
// Shared types, widths and constants for the sphere view-cone visibility block.
package svcv_pkg;

    localparam int COORD_W  = 24;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int AIM_W    = 16;
    localparam int RAD_W    = 23;
    localparam int FLAG_W   = 3;
    localparam int MUL_W    = 27;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int ACC_W    = 52;
    localparam int SQ_W     = 51;
    localparam int DIST_W   = 26;
    localparam int DOT_W    = 45;
    localparam int CW       = 35;
    localparam int CMP_W    = 64;
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W   = $clog2(CORDIC_STEPS);
    localparam int ATAN_ENTRIES = 24;
    localparam int ATAN_IDX_W = $clog2(ATAN_ENTRIES);
    localparam int IN_DATA_W  = 152;
    localparam int OUT_DATA_W = 8;

    localparam logic signed [CW-1:0] CONE_WIDEN_Q30  = CW'(843314880);
    localparam logic signed [CW-1:0] HALF_PI_Q30     = CW'(1686629713);
    localparam logic signed [CW-1:0] INV_GAIN_Q30    = CW'(652032874);
    localparam logic signed [DIFF_W-1:0] INSIDE_LIM  = DIFF_W'(8388607);

    localparam logic [31:0] ATAN_TABLE [ATAN_ENTRIES] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
        32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
        32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
    };

    typedef enum logic [1:0] {
        OP_BEGIN   = 2'd0,
        OP_CLUSTER = 2'd1,
        OP_VIEWER  = 2'd2,
        OP_NONE    = 2'd3
    } opcode_t;

    typedef struct packed {
        logic start;
    } svcv_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } svcv_stat_t;

endpackage

FILE: hdl/sphere_view_cone_visibility.sv
// Top level: item decode, shared multiplier, square root and verdict logic.
// Begin, cluster, skipped-viewer and no-op items finish in their accept cycle; a result follows.
// A tested viewer holds the input through 8 multiply steps, one inside check, 26 one-bit
// square-root steps, the CORDIC passes, 4 compare steps and a retire step that may wait
// on the output; a head inside the sphere skips to it. One item is in work at a time.
// Reset (rst_n low, asynchronous) clears the sphere state, the flags and the result.
module sphere_view_cone_visibility (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // pos_x, pos_y, pos_z, aim_x, aim_y, aim_z, sphere_radius, sphere_flags,
    // pvs_bit, has_unit, zero pad
    input  logic [svcv_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // opcode
    input  logic [1:0]                        s_axis_tuser,
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // visible, zero pad
    output logic [svcv_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
    import svcv_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_INS,
        S_SQRT,
        S_CORD,
        S_CMP,
        S_DONE
    } state_t;

    state_t                    state_reg;
    logic [2:0]                k_reg;
    logic [COORD_W-1:0]        cx_reg, cy_reg, cz_reg;
    logic [RAD_W-1:0]          radius_reg;
    logic                      eligible_reg, pvs_hit_reg, viewer_hit_reg;
    logic signed [DIFF_W-1:0]  dx_reg, dy_reg, dz_reg;
    logic signed [AIM_W-1:0]   ax_reg, ay_reg, az_reg;
    logic                      inside_reg;
    logic                      last_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic [ACC_W-1:0]          d2_reg;
    logic [ACC_W-1:0]          rr_reg;
    logic signed [DOT_W-1:0]   dot_reg;
    logic [SQ_W-1:0]           n_reg, res_reg, bit_reg;
    logic [DIST_W-1:0]         dist_reg;
    logic                      start_reg;
    logic signed [PROD_W-1:0]  lo_reg, hi_reg;
    logic                      hit_reg;
    logic                      out_valid_reg, visible_reg;

    logic                      accept;
    opcode_t                   op;
    logic signed [COORD_W-1:0] hx, hy, hz;
    logic signed [DIFF_W-1:0]  ndx, ndy, ndz;
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic [SQ_W-1:0]           trial;
    logic [SQ_W-1:0]           res_nx;
    logic signed [CMP_W-1:0]   lhs, rhs;
    logic                      out_free;
    logic                      pvs_nx, view_nx, elig_nx;
    logic                      test_start;
    logic                      emit;
    svcv_cmd_t                 cmd;
    svcv_stat_t                stat;
    logic signed [CW-1:0]      cosv;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign op            = opcode_t'(s_axis_tuser);
    assign test_start    = (op == OP_VIEWER) && s_axis_tdata[147] && !viewer_hit_reg;
    assign emit          = ((state_reg == S_IDLE) && accept && !test_start && s_axis_tlast) ||
                           ((state_reg == S_DONE) && out_free && last_reg);

    assign hx  = s_axis_tdata[23:0];
    assign hy  = s_axis_tdata[47:24];
    assign hz  = s_axis_tdata[71:48];
    assign ndx = DIFF_W'(signed'(cx_reg)) - DIFF_W'(hx);
    assign ndy = DIFF_W'(signed'(cy_reg)) - DIFF_W'(hy);
    assign ndz = DIFF_W'(signed'(cz_reg)) - DIFF_W'(hz);

    // Shared multiplier: squares, dot terms and r*r, then the two halves of c*D.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == S_MUL)
        begin
            unique case (k_reg)
                3'd0: begin mul_a = MUL_W'(dx_reg); mul_b = MUL_W'(dx_reg); end
                3'd1: begin mul_a = MUL_W'(dy_reg); mul_b = MUL_W'(dy_reg); end
                3'd2: begin mul_a = MUL_W'(dz_reg); mul_b = MUL_W'(dz_reg); end
                3'd3: begin mul_a = MUL_W'(ax_reg); mul_b = MUL_W'(dx_reg); end
                3'd4: begin mul_a = MUL_W'(ay_reg); mul_b = MUL_W'(dy_reg); end
                3'd5: begin mul_a = MUL_W'(az_reg); mul_b = MUL_W'(dz_reg); end
                3'd6:
                begin
                    mul_a = MUL_W'({1'b0, radius_reg});
                    mul_b = MUL_W'({1'b0, radius_reg});
                end
                default: ;
            endcase
        end
        else if (state_reg == S_CMP)
        begin
            mul_b = MUL_W'({1'b0, dist_reg});
            if (k_reg == 3'd0)
                mul_a = MUL_W'({1'b0, cosv[16:0]});
            else
                mul_a = MUL_W'(signed'(cosv[CW-1:17]));
        end
    end

    assign mul_p  = mul_a * mul_b;
    assign trial  = res_reg + bit_reg;
    assign res_nx = (n_reg >= trial) ? ((res_reg >> 1) + bit_reg) : (res_reg >> 1);
    assign lhs    = CMP_W'(dot_reg) <<< 16;
    assign rhs    = (CMP_W'(hi_reg) <<< 17) + CMP_W'(lo_reg);

    // Flag updates for the items that finish in the accept cycle.
    always_comb
    begin
        elig_nx = eligible_reg;
        pvs_nx  = pvs_hit_reg;
        view_nx = viewer_hit_reg;
        unique case (op)
            OP_BEGIN:
            begin
                elig_nx = s_axis_tdata[143] && s_axis_tdata[144] && !s_axis_tdata[145];
                pvs_nx  = 1'b0;
                view_nx = 1'b0;
            end
            OP_CLUSTER: pvs_nx = pvs_hit_reg || s_axis_tdata[146];
            OP_VIEWER, OP_NONE: ;
            default: ;
        endcase
    end

    assign cmd.start = start_reg;

    svcv_cordic u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .span   (dist_reg),
        .radius (radius_reg),
        .stat   (stat),
        .cosv   (cosv)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            k_reg          <= '0;
            cx_reg         <= '0;
            cy_reg         <= '0;
            cz_reg         <= '0;
            radius_reg     <= '0;
            eligible_reg   <= 1'b0;
            pvs_hit_reg    <= 1'b0;
            viewer_hit_reg <= 1'b0;
            start_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            visible_reg    <= 1'b0;
            last_reg       <= 1'b0;
        end
        else
        begin
            start_reg <= 1'b0;
            prod_reg  <= mul_p;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        last_reg <= s_axis_tlast;
                        if (op == OP_BEGIN)
                        begin
                            cx_reg     <= s_axis_tdata[23:0];
                            cy_reg     <= s_axis_tdata[47:24];
                            cz_reg     <= s_axis_tdata[71:48];
                            radius_reg <= s_axis_tdata[142:120];
                        end
                        eligible_reg <= elig_nx;
                        pvs_hit_reg  <= pvs_nx;
                        if (test_start)
                        begin
                            dx_reg     <= ndx;
                            dy_reg     <= ndy;
                            dz_reg     <= ndz;
                            ax_reg     <= s_axis_tdata[87:72];
                            ay_reg     <= s_axis_tdata[103:88];
                            az_reg     <= s_axis_tdata[119:104];
                            inside_reg <= (ndx <= INSIDE_LIM) && (ndx >= -INSIDE_LIM) &&
                                          (ndy <= INSIDE_LIM) && (ndy >= -INSIDE_LIM) &&
                                          (ndz <= INSIDE_LIM) && (ndz >= -INSIDE_LIM);
                            d2_reg     <= '0;
                            dot_reg    <= '0;
                            k_reg      <= '0;
                            state_reg  <= S_MUL;
                        end
                        else
                        begin
                            viewer_hit_reg <= view_nx;
                            if (s_axis_tlast)
                                visible_reg <= elig_nx && pvs_nx && view_nx;
                        end
                    end
                end
                S_MUL:
                begin
                    // The product of step k-1 is folded in while step k multiplies.
                    unique case (k_reg)
                        3'd1, 3'd2, 3'd3: d2_reg <= d2_reg + ACC_W'(prod_reg);
                        3'd4, 3'd5, 3'd6: dot_reg <= dot_reg + DOT_W'(prod_reg);
                        3'd7: rr_reg <= ACC_W'(prod_reg);
                        default: ;
                    endcase
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == 3'd7)
                        state_reg <= S_INS;
                end
                S_INS:
                begin
                    n_reg   <= SQ_W'(d2_reg);
                    res_reg <= '0;
                    bit_reg <= SQ_W'(1) << (SQ_W - 1);
                    if (inside_reg && (d2_reg < rr_reg))
                    begin
                        hit_reg   <= 1'b1;
                        state_reg <= S_DONE;
                    end
                    else
                        state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    if (n_reg >= trial)
                        n_reg <= n_reg - trial;
                    res_reg <= res_nx;
                    bit_reg <= bit_reg >> 2;
                    if (bit_reg[0])
                    begin
                        dist_reg  <= DIST_W'(res_nx);
                        start_reg <= 1'b1;
                        state_reg <= S_CORD;
                    end
                end
                S_CORD:
                begin
                    k_reg <= '0;
                    if (stat.done)
                        state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == 3'd1)
                        lo_reg <= prod_reg;
                    if (k_reg == 3'd2)
                        hi_reg <= prod_reg;
                    if (k_reg == 3'd3)
                    begin
                        hit_reg   <= (lhs > rhs);
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        viewer_hit_reg <= hit_reg;
                        if (last_reg)
                            visible_reg <= eligible_reg && pvs_hit_reg && hit_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
            if (emit)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - 1){1'b0}}, visible_reg};

`ifndef ASSERT_OFF
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (state_reg == S_IDLE) && !stat.busy)
        else $error("input ready while a viewer test is in work");
    a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> (state_reg == S_CORD))
        else $error("cone cosine finished outside the wait state");
    a_hit_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(viewer_hit_reg) |-> ($past(state_reg) == S_DONE))
        else $error("viewer hit set without a finished viewer test");
`endif

endmodule

FILE: hdl/svcv_cordic.sv
// Two CORDIC passes: atan2(r, D) by vectoring, then the widened cone cosine by rotation.
module svcv_cordic (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  svcv_pkg::svcv_cmd_t                  cmd,
    input  logic [svcv_pkg::DIST_W-1:0]          span,
    input  logic [svcv_pkg::RAD_W-1:0]           radius,
    output svcv_pkg::svcv_stat_t                 stat,
    output logic signed [svcv_pkg::CW-1:0]       cosv
);
    import svcv_pkg::*;

    typedef enum logic [2:0] {
        C_IDLE,
        C_VEC,
        C_PHI,
        C_ROT,
        C_FIN
    } cstate_t;

    cstate_t                  state_reg;
    logic signed [CW-1:0]     x_reg;
    logic signed [CW-1:0]     y_reg;
    logic signed [CW-1:0]     z_reg;
    logic [STEP_W-1:0]        i_reg;
    logic                     done_reg;
    logic signed [CW-1:0]     cosv_reg;
    logic signed [CW-1:0]     at;
    logic                     last_step;

    assign at        = CW'(ATAN_TABLE[ATAN_IDX_W'(i_reg)]);
    assign last_step = (i_reg == STEP_W'(CORDIC_STEPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
            i_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                C_IDLE:
                begin
                    if (cmd.start)
                    begin
                        x_reg     <= CW'(span);
                        y_reg     <= CW'(radius);
                        z_reg     <= '0;
                        i_reg     <= '0;
                        state_reg <= C_VEC;
                    end
                end
                C_VEC:
                begin
                    if (y_reg >= 0)
                    begin
                        x_reg <= x_reg + (y_reg >>> i_reg);
                        y_reg <= y_reg - (x_reg >>> i_reg);
                        z_reg <= z_reg + at;
                    end
                    else
                    begin
                        x_reg <= x_reg - (y_reg >>> i_reg);
                        y_reg <= y_reg + (x_reg >>> i_reg);
                        z_reg <= z_reg - at;
                    end
                    i_reg <= i_reg + 1'b1;
                    if (last_step)
                        state_reg <= C_PHI;
                end
                C_PHI:
                begin
                    z_reg     <= z_reg + CONE_WIDEN_Q30 - HALF_PI_Q30;
                    x_reg     <= INV_GAIN_Q30;
                    y_reg     <= '0;
                    i_reg     <= '0;
                    state_reg <= C_ROT;
                end
                C_ROT:
                begin
                    if (z_reg >= 0)
                    begin
                        x_reg <= x_reg - (y_reg >>> i_reg);
                        y_reg <= y_reg + (x_reg >>> i_reg);
                        z_reg <= z_reg - at;
                    end
                    else
                    begin
                        x_reg <= x_reg + (y_reg >>> i_reg);
                        y_reg <= y_reg - (x_reg >>> i_reg);
                        z_reg <= z_reg + at;
                    end
                    i_reg <= i_reg + 1'b1;
                    if (last_step)
                        state_reg <= C_FIN;
                end
                C_FIN:
                begin
                    cosv_reg  <= -y_reg;
                    done_reg  <= 1'b1;
                    state_reg <= C_IDLE;
                end
                default:
                    state_reg <= C_IDLE;
            endcase
        end
    end

    assign stat.busy = (state_reg != C_IDLE);
    assign stat.done = done_reg;
    assign cosv      = cosv_reg;

endmodule
